>>> rtl/core/nzma_pkg.sv
// Package for the three-channel nonzero moving average.
// Holds the function codes, sequencer states and fixed field widths.
// No dependencies.
`default_nettype none

package nzma_pkg;

  localparam int unsigned FuncW   = 2;
  localparam int unsigned SampleW = 16;
  localparam int unsigned HeartW  = 8;

  typedef enum logic [FuncW-1:0] {
    FUNC_SPEED   = 2'd0,
    FUNC_CADENCE = 2'd1,
    FUNC_HEART   = 2'd2,
    FUNC_TIMEOUT = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

>>> rtl/core/nonzero_moving_average_3ch.sv
// Three-channel moving average over nonzero samples (speed, cadence, heart
// rate). Each item updates one window, or clears speed and cadence on
// timeout, and returns one result. An item that divides passes through
// the load, divide and output states, the divide run by the shared
// one-bit-per-cycle divider; timeout and all-zero windows skip the divide
// and go from load to output. A new item is taken in the cycle the
// result is taken. Depends on nzma_pkg, nzma_window and nzma_div.
`default_nettype none

module nonzero_moving_average_3ch #(
  parameter int unsigned WINDOW = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [nzma_pkg::FuncW-1:0]   func_i,
  input  logic [nzma_pkg::SampleW-1:0] sample_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [nzma_pkg::FuncW-1:0]   channel_o,
  output logic [nzma_pkg::SampleW-1:0] average_o
);

  localparam int unsigned CntW  = $clog2(WINDOW + 1);
  localparam int unsigned SumW  = nzma_pkg::SampleW + CntW;
  localparam int unsigned HSumW = nzma_pkg::HeartW + CntW;

  nzma_pkg::state_e state_q, state_d;
  nzma_pkg::func_e  func_q, func_d;
  logic [nzma_pkg::SampleW-1:0] avg_q, avg_d;

  logic in_acc;
  logic out_acc;

  logic [SumW-1:0]  spd_sum, cad_sum, sel_sum;
  logic [HSumW-1:0] hr_sum;
  logic [CntW-1:0]  spd_cnt, cad_cnt, hr_cnt, sel_cnt;
  logic             div_start, div_done;
  logic [SumW-1:0]  div_quo;
  logic             push_spd, push_cad, push_hr, clr_sc;

  assign out_acc    = out_valid_o && !out_stall_i;
  assign in_stall_o = !(state_q == nzma_pkg::ST_IDLE ||
                        (state_q == nzma_pkg::ST_OUT && !out_stall_i));
  assign in_acc     = in_valid_i && !in_stall_o;

  assign push_spd = in_acc && (nzma_pkg::func_e'(func_i) == nzma_pkg::FUNC_SPEED);
  assign push_cad = in_acc && (nzma_pkg::func_e'(func_i) == nzma_pkg::FUNC_CADENCE);
  assign push_hr  = in_acc && (nzma_pkg::func_e'(func_i) == nzma_pkg::FUNC_HEART);
  assign clr_sc   = in_acc && (nzma_pkg::func_e'(func_i) == nzma_pkg::FUNC_TIMEOUT);

  nzma_window #(.DataW(nzma_pkg::SampleW), .Depth(WINDOW)) u_spd (
    .clk_i, .rst_ni,
    .push_i(push_spd), .clear_i(clr_sc), .data_i(sample_i),
    .sum_o(spd_sum), .cnt_o(spd_cnt)
  );

  nzma_window #(.DataW(nzma_pkg::SampleW), .Depth(WINDOW)) u_cad (
    .clk_i, .rst_ni,
    .push_i(push_cad), .clear_i(clr_sc), .data_i(sample_i),
    .sum_o(cad_sum), .cnt_o(cad_cnt)
  );

  nzma_window #(.DataW(nzma_pkg::HeartW), .Depth(WINDOW)) u_hr (
    .clk_i, .rst_ni,
    .push_i(push_hr), .clear_i(1'b0), .data_i(sample_i[nzma_pkg::HeartW-1:0]),
    .sum_o(hr_sum), .cnt_o(hr_cnt)
  );

  always_comb begin
    unique case (func_q)
      nzma_pkg::FUNC_SPEED: begin
        sel_sum = spd_sum;
        sel_cnt = spd_cnt;
      end
      nzma_pkg::FUNC_CADENCE: begin
        sel_sum = cad_sum;
        sel_cnt = cad_cnt;
      end
      nzma_pkg::FUNC_HEART: begin
        sel_sum = SumW'(hr_sum);
        sel_cnt = hr_cnt;
      end
      default: begin
        sel_sum = '0;
        sel_cnt = '0;
      end
    endcase
  end

  nzma_div #(.NumW(SumW), .DenW(CntW)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .num_i(sel_sum), .den_i(sel_cnt),
    .done_o(div_done), .quo_o(div_quo)
  );

  always_comb begin
    state_d   = state_q;
    func_d    = func_q;
    avg_d     = avg_q;
    div_start = 1'b0;
    unique case (state_q)
      nzma_pkg::ST_IDLE: begin
        if (in_acc) begin
          func_d  = nzma_pkg::func_e'(func_i);
          state_d = nzma_pkg::ST_LOAD;
        end
      end
      nzma_pkg::ST_LOAD: begin
        if (sel_cnt == '0) begin
          avg_d   = '0;
          state_d = nzma_pkg::ST_OUT;
        end else begin
          div_start = 1'b1;
          state_d   = nzma_pkg::ST_DIV;
        end
      end
      nzma_pkg::ST_DIV: begin
        if (div_done) begin
          avg_d   = div_quo[nzma_pkg::SampleW-1:0];
          state_d = nzma_pkg::ST_OUT;
        end
      end
      nzma_pkg::ST_OUT: begin
        if (in_acc) begin
          func_d  = nzma_pkg::func_e'(func_i);
          state_d = nzma_pkg::ST_LOAD;
        end else if (out_acc) begin
          state_d = nzma_pkg::ST_IDLE;
        end
      end
      default: state_d = nzma_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nzma_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    avg_q  <= avg_d;
  end

  assign out_valid_o = (state_q == nzma_pkg::ST_OUT);
  assign channel_o   = func_q;
  assign average_o   = avg_q;

  a_hr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && func_q == nzma_pkg::FUNC_HEART |->
      average_o[nzma_pkg::SampleW-1:nzma_pkg::HeartW] == '0)
    else $error("heart rate average above 8 bits");

  a_timeout_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && func_q == nzma_pkg::FUNC_TIMEOUT |-> average_o == '0)
    else $error("timeout result not zero");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == nzma_pkg::ST_DIV)
    else $error("divider finished outside divide state");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spd_cnt <= CntW'(WINDOW) && cad_cnt <= CntW'(WINDOW) && hr_cnt <= CntW'(WINDOW))
    else $error("nonzero count exceeds window");

  a_timeout_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_sc |=> spd_cnt == '0 && cad_cnt == '0 && spd_sum == '0 && cad_sum == '0)
    else $error("timeout did not clear speed and cadence");

endmodule

`default_nettype wire

>>> rtl/core/nzma_window.sv
// One sliding window as a shift line, with a running sum and count of its
// nonzero entries updated as the oldest entry drops out. No dependencies.
`default_nettype none

module nzma_window #(
  parameter int unsigned DataW = 16,
  parameter int unsigned Depth = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push_i,
  input  logic                                  clear_i,
  input  logic [DataW-1:0]                      data_i,
  output logic [DataW+$clog2(Depth+1)-1:0]      sum_o,
  output logic [$clog2(Depth+1)-1:0]            cnt_o
);

  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned SumW = DataW + CntW;

  logic [DataW-1:0] taps_q [Depth];
  logic [SumW-1:0]  sum_q, sum_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DataW-1:0] oldest;

  assign oldest = taps_q[0];

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (clear_i) begin
      sum_d = '0;
      cnt_d = '0;
    end else if (push_i) begin
      sum_d = sum_q + SumW'(data_i) - SumW'(oldest);
      cnt_d = cnt_q + CntW'(data_i != '0) - CntW'(oldest != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        taps_q[i] <= '0;
      end
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      if (clear_i) begin
        for (int i = 0; i < Depth; i++) begin
          taps_q[i] <= '0;
        end
      end else if (push_i) begin
        for (int i = 0; i + 1 < Depth; i++) begin
          taps_q[i] <= taps_q[i+1];
        end
        taps_q[Depth-1] <= data_i;
      end
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

  assign sum_o = sum_q;
  assign cnt_o = cnt_q;

endmodule

`default_nettype wire

>>> rtl/core/nzma_div.sv
// Restoring divider, one quotient bit per cycle, shared by all channels.
// No dependencies.
`default_nettype none

module nzma_div #(
  parameter int unsigned NumW = 19,
  parameter int unsigned DenW = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);

  localparam int unsigned StepW = $clog2(NumW + 1);

  logic [NumW-1:0]  quo_q, quo_d;
  logic [DenW-1:0]  rem_q, rem_d;
  logic [DenW-1:0]  den_q;
  logic [StepW-1:0] step_q, step_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DenW:0]    trial;
  logic [DenW:0]    diff;
  logic             fits;

  assign trial = {rem_q, quo_q[NumW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      step_d = StepW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d  = {quo_q[NumW-2:0], fits};
      rem_d  = fits ? diff[DenW-1:0] : trial[DenW-1:0];
      step_d = step_q - 1'b1;
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire
